// ----- sv/ldd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light dip detector package
// Shared widths, constants, register map and the structs passed between the
// detector core and the top level.
// ----------------------------------------------------------------------------
package ldd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int FRAC_W   = 16;
    localparam int AVG_W    = SAMPLE_W + FRAC_W;
    localparam int WIN_W    = 10;
    localparam int DIPS_W   = 9;
    localparam int TOTAL_W  = 40;
    localparam int SHIFT_W  = 5;
    localparam int ADDR_W   = 4;

    localparam logic [WIN_W-1:0]   WINDOW_CAPACITY = WIN_W'(1000);
    localparam logic [DIPS_W-1:0]  DIPS_MAX        = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(1);
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(16);

    localparam logic [SAMPLE_W-1:0] DROP_LEVEL_RESET      = SAMPLE_W'(228);
    localparam logic [SAMPLE_W-1:0] RISE_MARGIN_RESET     = SAMPLE_W'(68);
    localparam logic [SHIFT_W-1:0]  SMOOTHING_SHIFT_RESET = SHIFT_W'(10);

    localparam logic [1:0] REG_DROP_LEVEL      = 2'd0;
    localparam logic [1:0] REG_RISE_MARGIN     = 2'd1;
    localparam logic [1:0] REG_SMOOTHING_SHIFT = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] drop_level;
        logic [SAMPLE_W-1:0] rise_margin;
        logic [SHIFT_W-1:0]  smoothing_shift;
    } ldd_cfg_t;

    typedef struct packed {
        logic [AVG_W-1:0]   average;
        logic [WIN_W-1:0]   window_samples;
        logic [DIPS_W-1:0]  dip_count;
        logic [TOTAL_W-1:0] total_samples;
        logic               in_dip;
        logic               is_report;
    } ldd_result_t;

endpackage

// ----- sv/ldd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light dip detector core
// Holds the average, window and dip state, updates it for each accepted
// transfer and forms the matching result in the same cycle.
// ----------------------------------------------------------------------------
module ldd_core
    import ldd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                req_type,
    input  logic [SAMPLE_W-1:0] sample,
    input  ldd_cfg_t            cfg,
    output ldd_result_t         result
);

    logic [AVG_W-1:0]   avg_reg,   avg_next;
    logic [WIN_W-1:0]   win_reg,   win_next;
    logic [DIPS_W-1:0]  dips_reg,  dips_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               flag_reg,  flag_next;

    always_comb begin
        logic [SHIFT_W-1:0] sh;
        logic [AVG_W-1:0]   scaled;
        logic [AVG_W-1:0]   diff;
        logic [AVG_W:0]     round_add;
        logic [AVG_W:0]     neg_sum;
        logic [AVG_W-1:0]   avg_upd;
        logic [AVG_W:0]     s_plus_d;
        logic [AVG_W:0]     a_plus_h;
        logic               start;
        logic               stop;
        logic               flag1;
        logic [DIPS_W-1:0]  dips1;

        if (cfg.smoothing_shift < SHIFT_MIN) begin
            sh = SHIFT_MIN;
        end else if (cfg.smoothing_shift > SHIFT_MAX) begin
            sh = SHIFT_MAX;
        end else begin
            sh = cfg.smoothing_shift;
        end

        scaled    = {sample, FRAC_W'(0)};
        diff      = (scaled >= avg_reg) ? (scaled - avg_reg) : (avg_reg - scaled);
        round_add = ((AVG_W+1)'(1) << sh) - (AVG_W+1)'(1);
        neg_sum   = ({1'b0, diff} + round_add) >> sh;

        if (total_reg == '0) begin
            avg_upd = scaled;
        end else if (scaled >= avg_reg) begin
            avg_upd = avg_reg + (diff >> sh);
        end else begin
            avg_upd = avg_reg - neg_sum[AVG_W-1:0];
        end

        s_plus_d = {1'b0, scaled} + {1'b0, cfg.drop_level, FRAC_W'(0)};
        a_plus_h = {1'b0, avg_upd} + {1'b0, cfg.rise_margin, FRAC_W'(0)};
        start    = !flag_reg && (s_plus_d < {1'b0, avg_upd});
        flag1    = flag_reg || start;
        dips1    = (start && dips_reg != DIPS_MAX) ? dips_reg + DIPS_W'(1) : dips_reg;
        stop     = flag1 && (s_plus_d > a_plus_h);

        avg_next   = avg_reg;
        win_next   = win_reg;
        dips_next  = dips_reg;
        total_next = total_reg;
        flag_next  = flag_reg;

        result.average        = avg_reg;
        result.window_samples = win_reg;
        result.dip_count      = dips_reg;
        result.total_samples  = total_reg;
        result.in_dip         = flag_reg;
        result.is_report      = req_type;

        if (req_type) begin
            win_next  = '0;
            dips_next = '0;
            flag_next = 1'b0;
        end else begin
            avg_next   = avg_upd;
            total_next = (total_reg == TOTAL_MAX) ? total_reg
                                                  : total_reg + TOTAL_W'(1);
            if (win_reg < WINDOW_CAPACITY) begin
                win_next  = win_reg + WIN_W'(1);
                dips_next = dips1;
                flag_next = flag1 && !stop;
            end
            result.average        = avg_next;
            result.window_samples = win_next;
            result.dip_count      = dips_next;
            result.total_samples  = total_next;
            result.in_dip         = flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg   <= '0;
            win_reg   <= '0;
            dips_reg  <= '0;
            total_reg <= '0;
            flag_reg  <= 1'b0;
        end else if (accept) begin
            avg_reg   <= avg_next;
            win_reg   <= win_next;
            dips_reg  <= dips_next;
            total_reg <= total_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

// ----- sv/light_dip_detector.sv -----
`timescale 1ns / 1ps
// Each result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one transfer per cycle while the skid register is empty; the
// average update and the dip compares are combinational into the state registers.
// A two-entry output buffer keeps the input side open while one result waits.
// Reset (aresetn low, synchronous) clears core and valid state, loads register defaults.
// ----------------------------------------------------------------------------
// Light dip detector
// Tracks an exponential average of light samples, counts dips with
// hysteresis per window and reports the window on request.
// ----------------------------------------------------------------------------
module light_dip_detector
    import ldd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [SAMPLE_W-1:0] s_sample,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [AVG_W-1:0]    m_average,
    output logic [WIN_W-1:0]    m_window_samples,
    output logic [DIPS_W-1:0]   m_dip_count,
    output logic [TOTAL_W-1:0]  m_total_samples,
    output logic                m_in_dip,
    output logic                m_is_report
);

    ldd_cfg_t    cfg_reg;
    ldd_result_t result;
    ldd_result_t out_reg;
    ldd_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        accept;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drop_level      <= DROP_LEVEL_RESET;
            cfg_reg.rise_margin     <= RISE_MARGIN_RESET;
            cfg_reg.smoothing_shift <= SMOOTHING_SHIFT_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_DROP_LEVEL:      cfg_reg.drop_level      <= pwdata[SAMPLE_W-1:0];
                REG_RISE_MARGIN:     cfg_reg.rise_margin     <= pwdata[SAMPLE_W-1:0];
                REG_SMOOTHING_SHIFT: cfg_reg.smoothing_shift <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DROP_LEVEL:      prdata = 32'(cfg_reg.drop_level);
            REG_RISE_MARGIN:     prdata = 32'(cfg_reg.rise_margin);
            REG_SMOOTHING_SHIFT: prdata = 32'(cfg_reg.smoothing_shift);
            default:             prdata = '0;
        endcase
    end

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    ldd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .req_type (s_req_type),
        .sample   (s_sample),
        .cfg      (cfg_reg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_average        = out_reg.average;
    assign m_window_samples = out_reg.window_samples;
    assign m_dip_count      = out_reg.dip_count;
    assign m_total_samples  = out_reg.total_samples;
    assign m_in_dip         = out_reg.in_dip;
    assign m_is_report      = out_reg.is_report;

endmodule

// ----- sim/light_dip_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light dip detector testbench
// Drives sample and window-end transfers into the detector under random
// idling on both sides, keeps its own model of the average, window and dip
// state, and compares every result transfer field by field. The registers
// are rewritten between phases, their extremes included.
// ----------------------------------------------------------------------------
module light_dip_detector_tb;
    import ldd_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam logic       REQ_SAMPLE   = 1'b0;
    localparam logic       REQ_REPORT   = 1'b1;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_req_type = 1'b0;
    logic [SAMPLE_W-1:0] s_sample = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [AVG_W-1:0]    m_average;
    logic [WIN_W-1:0]    m_window_samples;
    logic [DIPS_W-1:0]   m_dip_count;
    logic [TOTAL_W-1:0]  m_total_samples;
    logic                m_in_dip;
    logic                m_is_report;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          stall_request = 1'b0;
    int unsigned stall_cycles_left = 0;
    int unsigned mismatches = 0;

    // Model of the detector's registers and state.
    logic [SAMPLE_W-1:0] cfg_drop = DROP_LEVEL_RESET;
    logic [SAMPLE_W-1:0] cfg_hyst = RISE_MARGIN_RESET;
    logic [SHIFT_W-1:0]  cfg_shift = SMOOTHING_SHIFT_RESET;
    logic [AVG_W-1:0]    avg_q = '0;
    logic [WIN_W-1:0]    win_q = '0;
    logic [DIPS_W-1:0]   dips_q = '0;
    logic [TOTAL_W-1:0]  total_q = '0;
    logic                dip_q = 1'b0;

    ldd_result_t light_results_q[$];

    light_dip_detector u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_average        (m_average),
        .m_window_samples (m_window_samples),
        .m_dip_count      (m_dip_count),
        .m_total_samples  (m_total_samples),
        .m_in_dip         (m_in_dip),
        .m_is_report      (m_is_report)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic ldd_result_t next_light_result(input logic req,
                                                      input logic [SAMPLE_W-1:0] smp);
        logic [63:0] scaled;
        logic [63:0] err;
        logic [63:0] drop_s;
        logic [63:0] hyst_s;
        logic [SHIFT_W-1:0] sh;
        ldd_result_t res;
        scaled = 64'(smp) << FRAC_W;
        drop_s = 64'(cfg_drop) << FRAC_W;
        hyst_s = 64'(cfg_hyst) << FRAC_W;
        if (cfg_shift < SHIFT_MIN) begin
            sh = SHIFT_MIN;
        end else if (cfg_shift > SHIFT_MAX) begin
            sh = SHIFT_MAX;
        end else begin
            sh = cfg_shift;
        end
        if (req == REQ_SAMPLE) begin
            if (total_q == '0) begin
                avg_q = scaled[AVG_W-1:0];
            end else if (scaled >= 64'(avg_q)) begin
                err = scaled - 64'(avg_q);
                avg_q = avg_q + AVG_W'(err >> sh);
            end else begin
                // Negative error: the update rounds toward minus infinity, as an arithmetic shift would.
                err = 64'(avg_q) - scaled;
                avg_q = avg_q - AVG_W'((err + ((64'd1 << sh) - 64'd1)) >> sh);
            end
            if (total_q != TOTAL_MAX) total_q = total_q + TOTAL_W'(1);
            if (win_q < WINDOW_CAPACITY) begin
                win_q = win_q + WIN_W'(1);
                if (!dip_q && (scaled + drop_s < 64'(avg_q))) begin
                    if (dips_q != DIPS_MAX) dips_q = dips_q + DIPS_W'(1);
                    dip_q = 1'b1;
                end
                if (dip_q && (scaled + drop_s > 64'(avg_q) + hyst_s)) dip_q = 1'b0;
            end
        end
        res.average        = avg_q;
        res.window_samples = win_q;
        res.dip_count      = dips_q;
        res.total_samples  = total_q;
        res.in_dip         = dip_q;
        res.is_report      = req;
        if (req == REQ_REPORT) begin
            win_q  = '0;
            dips_q = '0;
            dip_q  = 1'b0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            light_results_q.push_back(next_light_result(s_req_type, s_sample));
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        ldd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (light_results_q.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with none expected, actual average %0d",
                         $time, m_average);
            end else begin
                want = light_results_q.pop_front();
                check_field("average", 64'(want.average), 64'(m_average));
                check_field("window_samples", 64'(want.window_samples),
                            64'(m_window_samples));
                check_field("dip_count", 64'(want.dip_count), 64'(m_dip_count));
                check_field("total_samples", 64'(want.total_samples),
                            64'(m_total_samples));
                check_field("in_dip", 64'(want.in_dip), 64'(m_in_dip));
                check_field("is_report", 64'(want.is_report), 64'(m_is_report));
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_cycles_left > 0) begin
            m_ready <= 1'b0;
            stall_cycles_left--;
        end else if (stall_request) begin
            stall_request = 1'b0;
            stall_cycles_left = 60;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic req, input logic [SAMPLE_W-1:0] smp);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_sample   <= smp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (light_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_DROP_LEVEL:      cfg_drop = value[SAMPLE_W-1:0];
            REG_RISE_MARGIN:     cfg_hyst = value[SAMPLE_W-1:0];
            REG_SMOOTHING_SHIFT: cfg_shift = value[SHIFT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all_regs(input int drop, input int hyst, input int shift);
        write_reg(REG_DROP_LEVEL, 32'(drop));
        write_reg(REG_RISE_MARGIN, 32'(hyst));
        write_reg(REG_SMOOTHING_SHIFT, 32'(shift));
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_code(input int code);
        if (code < 0) return '0;
        if (code > 4095) return '1;
        return SAMPLE_W'(code);
    endfunction

    // Mostly a steady light level with bursts of dark samples, plus noise and
    // window-end transfers at random points.
    task automatic send_light_burst(input int count);
        int  base;
        bit  dark;
        int  r;
        base = $urandom_range(800, 3800);
        dark = 1'b0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 15) dark = !dark;
            if ($urandom_range(0, 99) < 3) base = $urandom_range(0, 4095);
            if (r < 6) begin
                send_item(REQ_REPORT, SAMPLE_W'($urandom));
            end else if (r < 14) begin
                send_item(REQ_SAMPLE, SAMPLE_W'($urandom));
            end else if (dark) begin
                send_item(REQ_SAMPLE, clamp_code(base - int'(cfg_drop)
                                                 - int'($urandom_range(0, 300))));
            end else begin
                send_item(REQ_SAMPLE, clamp_code(base + int'($urandom_range(0, 80)) - 40));
            end
        end
    endtask

    task automatic test_directed;
        send_item(REQ_REPORT, 12'd0);
        send_item(REQ_SAMPLE, 12'd2000);
        send_item(REQ_SAMPLE, 12'd2000);
        send_item(REQ_SAMPLE, 12'd1700);
        send_item(REQ_SAMPLE, 12'd1760);
        send_item(REQ_REPORT, 12'hFFF);
        send_item(REQ_SAMPLE, 12'd1700);
        send_item(REQ_SAMPLE, 12'd1900);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd0);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'hAAA);
        send_item(REQ_SAMPLE, 12'h555);
        send_item(REQ_SAMPLE, 12'd0);
        send_item(REQ_REPORT, 12'd0);
        send_item(REQ_SAMPLE, 12'd1);
        send_item(REQ_REPORT, 12'd0);
        drain();
    endtask

    task automatic test_register_extremes;
        write_all_regs(0, 0, 1);
        send_light_burst(14);
        drain();
        write_all_regs(4095, 4095, 16);
        send_light_burst(14);
        drain();
        // Shift values outside the legal range are clamped by the block.
        write_all_regs(0, 4095, 0);
        send_light_burst(14);
        drain();
        write_all_regs(4095, 0, 31);
        send_light_burst(14);
        drain();
        write_all_regs(120, 20, 17);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_light_burst(14);
        drain();
    endtask

    task automatic test_random_traffic(input int count);
        write_all_regs($urandom_range(0, 700), $urandom_range(0, 255), $urandom_range(1, 16));
        send_light_burst(count);
        drain();
    endtask

    task automatic test_output_stall;
        stall_request = 1'b1;
        send_light_burst(40);
        drain();
    endtask

    // Samples past the window capacity move the average and the total only.
    task automatic test_full_window;
        write_all_regs(50, 10, 3);
        send_item(REQ_REPORT, 12'd0);
        for (int i = 0; i < 1012; i++) begin
            send_item(REQ_SAMPLE, (i % 5 < 3) ? 12'd3000 : 12'd500);
        end
        send_item(REQ_REPORT, 12'd0);
        send_item(REQ_SAMPLE, 12'd500);
        drain();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 33;
        rx_idle_pct = 47;
        test_directed();
        test_register_extremes();
        test_random_traffic(220);
        tx_idle_pct = 47;
        rx_idle_pct = 33;
        test_random_traffic(220);
        test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_full_window();
        test_random_traffic(220);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
